// ----- rtl/csl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the caseless substring line finder.
// No dependencies.
package csl_pkg;

  // Character handling
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Pattern register file: four 64-bit words of eight bytes each
  localparam int PAT_REG_COUNT = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int PAT_BYTES     = 32;
  localparam int PAT_BITS      = PAT_REG_COUNT * CFG_DATA_W;
  localparam int PAT_LEN_W     = 6;
  localparam int CFG_IDX_W     = 3;

  // Fixed widths of the result fields
  localparam int OFFSET_OUT_W = 32;
  localparam int LINE_OUT_W   = 24;

  // Result queue
  localparam int OUT_FIFO_DEPTH = 4;
  localparam int OUT_FIFO_AW    = 2;
  localparam int OUT_FIFO_CW    = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LOW    = 3'd0,
    CFG_PAT_SECOND = 3'd1,
    CFG_PAT_THIRD  = 3'd2,
    CFG_PAT_HIGH   = 3'd3,
    CFG_PAT_LEN    = 3'd4,
    CFG_WIDE_EN    = 3'd5
  } cfg_idx_t;

  // Report kinds
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_WIDE    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  // One result beat
  typedef struct packed {
    kind_t                   kind;
    logic [OFFSET_OUT_W-1:0] offset;
    logic [LINE_OUT_W-1:0]   line;
    logic                    had_match;
    logic                    last;
  } report_t;

  // Window compare outcome
  typedef struct packed {
    logic byte_eq;
    logic wide_eq;
  } match_t;

  // Lower-case fold: only 'A'..'Z' move
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

endpackage

// ----- rtl/csl_matcher.sv -----
`timescale 1ns / 1ps
// Parallel window compare for the byte form and the UTF-16LE form of the pattern.
// Depends on csl_pkg.
module csl_matcher import csl_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 32,
  localparam int WIN = 2 * MAX_PATTERN_BYTES,
  localparam int NW  = $clog2(MAX_PATTERN_BYTES + 1),
  localparam int IW  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1
) (
  input  logic [WIN-1:0][7:0] window,
  input  logic [PAT_BITS-1:0] pattern,
  input  logic [NW-1:0]       pat_len,
  output match_t              result
);

  logic [MAX_PATTERN_BYTES-1:0][7:0] pat_fold;
  logic [MAX_PATTERN_BYTES-1:0][7:0] aligned;
  logic [MAX_PATTERN_BYTES-1:0][NW-1:0] src_idx;
  logic [MAX_PATTERN_BYTES-1:0] ok_byte;
  logic [MAX_PATTERN_BYTES-1:0] ok_wide;

  // Folded pattern bytes; bytes past the register file read as zero
  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      if (i < PAT_BYTES) begin
        pat_fold[i] = fold_byte(pattern[(i % PAT_BYTES) * 8 +: 8]);
      end else begin
        pat_fold[i] = '0;
      end
    end
  end

  // Reverse the pattern against the window: slot j holds pattern byte n-1-j,
  // so the last pattern byte lines up with the newest window byte
  always_comb begin
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      src_idx[j] = pat_len - NW'(1) - NW'(j);
      aligned[j] = pat_fold[src_idx[j][IW-1:0]];
    end
  end

  // Per-slot equality, slots at or beyond the length always pass
  always_comb begin
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      ok_byte[j] = (NW'(j) >= pat_len) || (window[j] == aligned[j]);
      ok_wide[j] = (NW'(j) >= pat_len) ||
                   ((window[2*j+1] == aligned[j]) && (window[2*j] == 8'h00));
    end
  end

  assign result.byte_eq = &ok_byte;
  assign result.wide_eq = &ok_wide;

endmodule

// ----- rtl/csl_out_fifo.sv -----
`timescale 1ns / 1ps
// Small result queue: takes up to two report beats per cycle, hands out one.
// Depends on csl_pkg.
module csl_out_fifo import csl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             push_cnt,
  input  report_t                push_first,
  input  report_t                push_second,
  output logic [OUT_FIFO_CW-1:0] level,
  output logic                   out_valid,
  input  logic                   out_stall,
  output report_t                out_data
);

  report_t entry_r [OUT_FIFO_DEPTH];
  logic [OUT_FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OUT_FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OUT_FIFO_CW-1:0] count_r, count_nxt;
  logic                   pop;

  assign out_valid = (count_r != '0);
  assign out_data  = entry_r[rd_ptr_r];
  assign level     = count_r;
  assign pop       = out_valid && !out_stall;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + OUT_FIFO_AW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + OUT_FIFO_AW'(pop);
    count_nxt  = count_r + OUT_FIFO_CW'(push_cnt) - OUT_FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage, first beat at the write pointer, second one after it
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      entry_r[wr_ptr_r] <= push_first;
    end
    if (push_cnt == 2'd2) begin
      entry_r[wr_ptr_r + OUT_FIFO_AW'(1)] <= push_second;
    end
  end

endmodule

// ----- rtl/caseless_substring_line_finder.sv -----
`timescale 1ns / 1ps
// Top level of the caseless substring line finder: window, counters, line history.
// Depends on csl_pkg, csl_matcher and csl_out_fifo.
//
//   channel | signals                               | handshake
//   --------+---------------------------------------+-------------------------
//   in      | in_data_byte, in_end_of_file          | in_valid / in_stall
//   out     | out_report_kind .. out_last_report    | out_valid / out_stall
//   cfg     | cfg_index, cfg_data                   | cfg_valid / cfg_ready
//
// One byte is taken per cycle while in_stall is low. Its compare is done from
// the registered window, and its reports enter a four-beat result queue once
// the queue has room for two beats. A byte yields at most two beats (match and
// end-of-file summary); the out side hands out one beat a cycle while out_stall
// is low, so the in side stalls only when the queue cannot take two more beats.
// Synchronous reset, no clearing pass; the configuration port is always ready.
module caseless_substring_line_finder import csl_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 32,
  parameter int LINE_COUNT_BITS   = 24,
  parameter int OFFSET_BITS       = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input bytes
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_end_of_file,
  // reports
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_report_kind,
  output logic [OFFSET_OUT_W-1:0] out_start_offset,
  output logic [LINE_OUT_W-1:0]   out_line_number,
  output logic                    out_file_had_match,
  output logic                    out_last_report,
  // configuration
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int WIN   = 2 * MAX_PATTERN_BYTES;
  localparam int NW    = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int PW    = $clog2(WIN);
  localparam int LDEPTH = 2 ** PW;
  localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;
  localparam logic [OFFSET_BITS-1:0]     OFFSET_MAX = '1;

  // Configuration registers
  logic [PAT_REG_COUNT-1:0][CFG_DATA_W-1:0] pat_r;
  logic [PAT_LEN_W-1:0]                     pat_len_r;
  logic                                     wide_en_r;

  // Stream state
  logic [WIN-1:0][7:0]        window_r, window_base;
  logic                       clr_pend_r;
  logic [OFFSET_BITS-1:0]     bytes_seen_r, bytes_seen_nxt;
  logic [LINE_COUNT_BITS-1:0] line_r, line_nxt;
  logic                       any_match_r;

  // Line history, one entry per window position
  logic [LINE_COUNT_BITS-1:0] line_mem [LDEPTH];
  logic [PW-1:0]              wptr_r;
  logic [PW-1:0]              rd_b_addr, rd_w_addr;
  logic [LINE_COUNT_BITS-1:0] line_b_r, line_w_r;

  // Compare stage
  logic                       s2_v_r;
  logic [OFFSET_BITS-1:0]     pos_r;
  logic [LINE_COUNT_BITS-1:0] line_pre_r;
  logic                       nl_r;
  logic                       s2_eof_r;

  logic [7:0]                 fb;
  logic                       acc, adv;
  logic [NW-1:0]              eff_len, len_m1;
  logic [NW:0]                wide_m1, span_m1;
  logic [PAT_BITS-1:0]        pat_flat;
  match_t                     cmp;
  logic                       hit_b, hit_w, hit;
  logic [OFFSET_BITS-1:0]     start_full;
  logic [LINE_COUNT_BITS-1:0] start_line, line_post;
  report_t                    rep_match, rep_sum, push_first;
  logic [1:0]                 push_cnt;
  logic [OUT_FIFO_CW-1:0]     fifo_level;
  report_t                    fifo_out;

  // ------------------------------------------------------------------
  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r     <= '0;
      pat_len_r <= PAT_LEN_W'(1);
      wide_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAT_LOW:    pat_r[0]  <= cfg_data;
        CFG_PAT_SECOND: pat_r[1]  <= cfg_data;
        CFG_PAT_THIRD:  pat_r[2]  <= cfg_data;
        CFG_PAT_HIGH:   pat_r[3]  <= cfg_data;
        CFG_PAT_LEN:    pat_len_r <= cfg_data[PAT_LEN_W-1:0];
        CFG_WIDE_EN:    wide_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective length: zero counts as one, clamp to MAX_PATTERN_BYTES
  always_comb begin
    if (pat_len_r == '0) begin
      eff_len = NW'(1);
    end else if (32'(pat_len_r) > MAX_PATTERN_BYTES) begin
      eff_len = NW'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = NW'(pat_len_r);
    end
    len_m1  = eff_len - NW'(1);
    wide_m1 = {eff_len, 1'b0} - (NW+1)'(1);
  end

  assign pat_flat = pat_r;

  // ------------------------------------------------------------------
  // Handshake: compare stage frees when the queue has room for two beats
  assign adv      = s2_v_r && (32'(fifo_level) <= OUT_FIFO_DEPTH - 2);
  assign in_stall = s2_v_r && !adv;
  assign acc      = in_valid && !in_stall;
  assign fb       = fold_byte(in_data_byte);

  // ------------------------------------------------------------------
  // Window shift; a finished file leaves a clear pending for the next beat
  assign window_base = clr_pend_r ? '0 : window_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      window_r <= {window_base[WIN-2:0], fb};
    end
  end

  // Per-file counters, updated on the accepted beat
  always_comb begin
    if (in_end_of_file) begin
      bytes_seen_nxt = '0;
      line_nxt       = LINE_COUNT_BITS'(1);
    end else begin
      bytes_seen_nxt = (bytes_seen_r == OFFSET_MAX) ? bytes_seen_r
                                                    : bytes_seen_r + OFFSET_BITS'(1);
      line_nxt       = ((fb == CHAR_NEWLINE) && (line_r != LINE_MAX))
                       ? line_r + LINE_COUNT_BITS'(1) : line_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_pend_r   <= 1'b1;
      bytes_seen_r <= '0;
      line_r       <= LINE_COUNT_BITS'(1);
      wptr_r       <= '0;
      s2_v_r       <= 1'b0;
      any_match_r  <= 1'b0;
    end else begin
      if (acc) begin
        clr_pend_r   <= in_end_of_file;
        bytes_seen_r <= bytes_seen_nxt;
        line_r       <= line_nxt;
        wptr_r       <= wptr_r + PW'(1);
      end
      if (acc) begin
        s2_v_r <= 1'b1;
      end else if (adv) begin
        s2_v_r <= 1'b0;
      end
      if (adv) begin
        any_match_r <= s2_eof_r ? 1'b0 : (any_match_r || hit);
      end
    end
  end

  // Snapshot of the counters as they stood before this beat
  always_ff @(posedge clk) begin
    if (acc) begin
      pos_r      <= bytes_seen_r;
      line_pre_r <= line_r;
      nl_r       <= (fb == CHAR_NEWLINE);
      s2_eof_r   <= in_end_of_file;
    end
  end

  // ------------------------------------------------------------------
  // Line history: write the line of this byte, read the lines where a byte
  // form and a wide form match would start; a one-byte match starts here
  assign rd_b_addr = wptr_r - PW'(len_m1);
  assign rd_w_addr = wptr_r - PW'(wide_m1);

  always_ff @(posedge clk) begin
    if (acc) begin
      line_mem[wptr_r] <= line_r;
      line_b_r         <= (len_m1 == '0) ? line_r : line_mem[rd_b_addr];
      line_w_r         <= line_mem[rd_w_addr];
    end
  end

  // ------------------------------------------------------------------
  // Compare stage
  csl_matcher #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
  ) u_matcher (
    .window  (window_r),
    .pattern (pat_flat),
    .pat_len (eff_len),
    .result  (cmp)
  );

  assign hit_b = cmp.byte_eq && (pos_r >= OFFSET_BITS'(len_m1));
  assign hit_w = wide_en_r && cmp.wide_eq && (pos_r >= OFFSET_BITS'(wide_m1));
  assign hit   = hit_b || hit_w;

  // Byte form wins when both forms end on the same byte
  always_comb begin
    span_m1    = hit_b ? {1'b0, len_m1} : wide_m1;
    start_full = pos_r - OFFSET_BITS'(span_m1);
    if (line_pre_r == LINE_MAX) begin
      start_line = LINE_MAX;
    end else begin
      start_line = hit_b ? line_b_r : line_w_r;
    end
    line_post = (nl_r && (line_pre_r != LINE_MAX)) ? line_pre_r + LINE_COUNT_BITS'(1)
                                                   : line_pre_r;
  end

  // Report beats
  always_comb begin
    rep_match.kind      = hit_b ? KIND_BYTE : KIND_WIDE;
    rep_match.offset    = OFFSET_OUT_W'(start_full);
    rep_match.line      = LINE_OUT_W'(start_line);
    rep_match.had_match = 1'b1;
    rep_match.last      = !s2_eof_r;

    rep_sum.kind        = KIND_SUMMARY;
    rep_sum.offset      = '0;
    rep_sum.line        = LINE_OUT_W'(line_post);
    rep_sum.had_match   = any_match_r || hit;
    rep_sum.last        = 1'b1;

    push_first = hit ? rep_match : rep_sum;
    if (adv) begin
      push_cnt = 2'(hit) + 2'(s2_eof_r);
    end else begin
      push_cnt = 2'd0;
    end
  end

  csl_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_cnt    (push_cnt),
    .push_first  (push_first),
    .push_second (rep_sum),
    .level       (fifo_level),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (fifo_out)
  );

  assign out_report_kind    = fifo_out.kind;
  assign out_start_offset   = fifo_out.offset;
  assign out_line_number    = fifo_out.line;
  assign out_file_had_match = fifo_out.had_match;
  assign out_last_report    = fifo_out.last;

  // ------------------------------------------------------------------
  // Checks

  // An empty compare stage never holds back the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_v_r |-> !in_stall)
    else $error("input stalled with an empty compare stage");

  // The room check keeps the queue from overflowing
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fifo_level) <= OUT_FIFO_DEPTH)
    else $error("result queue overflow");

  // An end-of-file beat resets the per-file counters
  a_eof_clears_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_end_of_file) |=> (bytes_seen_r == '0) && (line_r == LINE_COUNT_BITS'(1)))
    else $error("counters not cleared after end of file");

  // The match flag is dropped once the summary has been queued
  a_eof_clears_match: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_eof_r) |=> !any_match_r)
    else $error("match flag survives end of file");

endmodule

// ----- tb/caseless_substring_line_finder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the caseless substring line finder: byte stream in, match and
// end-of-file reports out, checked against an in-bench predictor. Depends on csl_pkg and the RTL.
module caseless_substring_line_finder_tb;
  import csl_pkg::*;

  localparam int WIN_DEPTH     = 2 * PAT_BYTES;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 700;
  localparam int RANDOM_PHASES = 10;
  localparam int HOLD_OFF_LEN  = 400;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              in_data_byte;
  logic                    in_end_of_file;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_report_kind;
  logic [OFFSET_OUT_W-1:0] out_start_offset;
  logic [LINE_OUT_W-1:0]   out_line_number;
  logic                    out_file_had_match;
  logic                    out_last_report;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  // Predictor copy of the configuration
  logic [CFG_DATA_W-1:0]   pat_word [PAT_REG_COUNT];
  logic [PAT_LEN_W-1:0]    pat_len;
  logic                    wide_on;

  // Predictor copy of the per-file state
  logic [7:0]              fold_win [WIN_DEPTH];
  logic [OFFSET_OUT_W-1:0] file_bytes;
  logic [LINE_OUT_W-1:0]   file_line;
  logic                    file_hit;

  report_t                 pending_reports [$];
  report_t                 want;
  int                      errors = 0;
  int                      bytes_sent = 0;
  int                      cycle_count = 0;

  // Result-side stall pattern
  int                      hold_off_request = 0;
  int                      seg_left = 0;
  logic                    seg_stall = 1'b0;
  int                      seg_pick;

  caseless_substring_line_finder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_file    (in_end_of_file),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_report_kind   (out_report_kind),
    .out_start_offset  (out_start_offset),
    .out_line_number   (out_line_number),
    .out_file_had_match(out_file_had_match),
    .out_last_report   (out_last_report),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #10 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[caseless_substring_line_finder] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] to_lower(input logic [7:0] b);
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

  function automatic int match_len();
    int n;
    n = int'(pat_len);
    if (n == 0) n = 1;
    if (n > PAT_BYTES) n = PAT_BYTES;
    return n;
  endfunction

  function automatic logic [7:0] pattern_char(input int k);
    if (k >= PAT_BYTES) return 8'h00;
    return to_lower(pat_word[k / 8][(k % 8) * 8 +: 8]);
  endfunction

  task automatic clear_file();
    foreach (fold_win[i]) fold_win[i] = 8'h00;
    file_bytes = '0;
    file_line  = LINE_OUT_W'(1);
    file_hit   = 1'b0;
  endtask

  // Append one expected report beat
  task automatic queue_report(input report_t rep);
    pending_reports = {pending_reports, rep};
  endtask

  // Shift one byte into the window and queue the reports it causes
  task automatic predict_byte(input logic [7:0] raw, input logic eof);
    logic [7:0] b;
    logic [7:0] want_b;
    int         n;
    int         span;
    int         nl;
    longint     have;
    logic       hit_b;
    logic       hit_w;
    report_t    rep;
    b    = to_lower(raw);
    n    = match_len();
    have = longint'(file_bytes) + 1;
    for (int k = WIN_DEPTH - 1; k > 0; k--) fold_win[k] = fold_win[k - 1];
    fold_win[0] = b;

    hit_b = (have >= n);
    for (int k = 0; k < n; k++)
      if (fold_win[n - 1 - k] != pattern_char(k)) hit_b = 1'b0;
    hit_w = wide_on && (have >= 2 * n);
    for (int k = 0; k < 2 * n; k++) begin
      want_b = (k % 2) ? 8'h00 : pattern_char(k / 2);
      if (fold_win[2 * n - 1 - k] != want_b) hit_w = 1'b0;
    end

    // byte form wins when both end here
    if (hit_b || hit_w) begin
      span      = hit_b ? n : 2 * n;
      file_hit  = 1'b1;
      rep.kind  = hit_b ? KIND_BYTE : KIND_WIDE;
      rep.offset = file_bytes - OFFSET_OUT_W'(span - 1);
      if (file_line == '1) begin
        rep.line = '1;
      end else begin
        nl = 0;
        for (int k = 1; k < span; k++)
          if (fold_win[k] == CHAR_NEWLINE) nl++;
        rep.line = (nl >= file_line) ? LINE_OUT_W'(1) : file_line - LINE_OUT_W'(nl);
      end
      rep.had_match = 1'b1;
      rep.last      = !eof;
      queue_report(rep);
    end

    if (file_bytes != '1) file_bytes++;
    if (b == CHAR_NEWLINE && file_line != '1) file_line++;

    if (eof) begin
      rep.kind      = KIND_SUMMARY;
      rep.offset    = '0;
      rep.line      = file_line;
      rep.had_match = file_hit;
      rep.last      = 1'b1;
      queue_report(rep);
      clear_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_off_request > 0) begin
        seg_left         = hold_off_request;
        seg_stall        = 1'b1;
        hold_off_request = 0;
      end else if (seg_left == 0) begin
        seg_pick = $urandom_range(0, 99);
        if (seg_pick < 55) begin
          seg_stall = 1'b0;
          seg_left  = $urandom_range(1, 24);
        end else if (seg_pick < 90) begin
          seg_stall = 1'b1;
          seg_left  = $urandom_range(1, 3);
        end else begin
          seg_stall = 1'b1;
          seg_left  = $urandom_range(8, 40);
        end
      end
      out_stall <= seg_stall;
      seg_left--;
    end
  end

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report expected none actual kind %0d offset %0h line %0d", $time,
                 out_report_kind, out_start_offset, out_line_number);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("report_kind", want.kind, out_report_kind);
        check_field("start_offset", want.offset, out_start_offset);
        check_field("line_number", want.line, out_line_number);
        check_field("file_had_match", want.had_match, out_file_had_match);
        check_field("last_report", want.last, out_last_report);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // One beat on the input side; in_valid stays high for a back-to-back beat
  task automatic send_byte(input logic [7:0] d, input logic eof);
    in_valid       <= 1'b1;
    in_data_byte   <= d;
    in_end_of_file <= eof;
    do @(posedge clk); while (in_stall);
    predict_byte(d, eof);
    bytes_sent++;
  endtask

  task automatic input_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_file(input logic [7:0] fb[$], input logic calm);
    for (int i = 0; i < fb.size(); i++) begin
      send_byte(fb[i], i == fb.size() - 1);
      input_gap(calm ? 0 : pick_gap());
    end
  endtask

  // Drain every expected report, then let the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_PAT_LOW:    pat_word[0] = data;
      CFG_PAT_SECOND: pat_word[1] = data;
      CFG_PAT_THIRD:  pat_word[2] = data;
      CFG_PAT_HIGH:   pat_word[3] = data;
      CFG_PAT_LEN:    pat_len     = data[PAT_LEN_W-1:0];
      CFG_WIDE_EN:    wide_on     = data[0];
      default: ;
    endcase
  endtask

  // Full setting; unused upper bits of the length and enable beats carry noise
  task automatic apply_setting(input logic [PAT_BITS-1:0] pat, input logic [PAT_LEN_W-1:0] len,
                               input logic wide);
    logic [CFG_DATA_W-1:0] junk;
    wait_idle();
    cfg_write(CFG_PAT_LOW,    pat[0 * CFG_DATA_W +: CFG_DATA_W]);
    cfg_write(CFG_PAT_SECOND, pat[1 * CFG_DATA_W +: CFG_DATA_W]);
    cfg_write(CFG_PAT_THIRD,  pat[2 * CFG_DATA_W +: CFG_DATA_W]);
    cfg_write(CFG_PAT_HIGH,   pat[3 * CFG_DATA_W +: CFG_DATA_W]);
    junk = {$urandom(), $urandom()};
    junk[PAT_LEN_W-1:0] = len;
    cfg_write(CFG_PAT_LEN, junk);
    junk = {$urandom(), $urandom()};
    junk[0] = wide;
    cfg_write(CFG_WIDE_EN, junk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PAT_BITS-1:0] random_pattern(input logic zero_tail);
    logic [PAT_BITS-1:0] pat;
    logic [7:0]          c;
    int                  r;
    for (int i = 0; i < PAT_BYTES; i++) begin
      r = $urandom_range(0, 9);
      if (zero_tail)      c = (r < 5) ? 8'h00 : ((r < 8) ? 8'h61 : 8'h41);
      else if (r < 4)     c = 8'h61 + 8'($urandom_range(0, 2)) - (r[0] ? CASE_OFFSET : 8'h00);
      else if (r < 6)     c = CHAR_NEWLINE;
      else if (r < 7)     c = 8'h00;
      else                c = 8'($urandom_range(0, 255));
      pat[i * 8 +: 8] = c;
    end
    return pat;
  endfunction

  function automatic logic [7:0] vary_case(input logic [7:0] b);
    logic [7:0] f;
    f = to_lower(b);
    if (f >= 8'h61 && f <= 8'h7A && $urandom_range(0, 1)) return f - CASE_OFFSET;
    return f;
  endfunction

  // A file built mostly from pattern copies (plain, wide, damaged) among noise and newlines
  task automatic random_file();
    logic [7:0] fb [$];
    int         n;
    int         target;
    int         r;
    int         cut;
    n      = match_len();
    target = ($urandom_range(0, 9) == 0) ? $urandom_range(90, 160) : $urandom_range(1, 40);
    while (fb.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        for (int k = 0; k < n; k++) fb = {fb, vary_case(pattern_char(k))};
      end else if (r < 45) begin
        for (int k = 0; k < n; k++) begin
          fb = {fb, vary_case(pattern_char(k))};
          fb = {fb, 8'h00};
        end
      end else if (r < 57) begin
        cut = $urandom_range(0, n - 1);
        for (int k = 0; k < n; k++) begin
          if (k == cut && r[0]) break;
          fb = {fb, (k == cut) ? 8'($urandom_range(0, 255)) : vary_case(pattern_char(k))};
        end
      end else if (r < 70) begin
        repeat ($urandom_range(1, 3)) fb = {fb, CHAR_NEWLINE};
      end else begin
        repeat ($urandom_range(1, 6))
          fb = {fb, $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                         : vary_case(pattern_char($urandom_range(0, n - 1)))};
      end
    end
    send_file(fb, $urandom_range(0, 3) == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset setting: pattern is a single zero byte, wide search on; the second zero
  // ends both forms at once, the first is too early for the wide form
  task automatic test_reset_defaults();
    logic [7:0] seq [$] = '{8'h00, 8'h00, 8'h41, 8'h0A, 8'hFF, 8'h00};
    send_file(seq, 1'b1);
  endtask

  // Mixed-case pattern holding a newline, matched in plain and wide form, then fold edges
  task automatic test_case_fold();
    logic [PAT_BITS-1:0] pat;
    logic [7:0] seq [$] = '{8'h61, 8'h5A, 8'h0A, 8'h41, 8'h00, 8'h7A, 8'h00, 8'h0A,
                            8'h00, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF};
    pat = random_pattern(1'b0);
    pat[23:0] = {CHAR_NEWLINE, 8'h7A, CHAR_UPPER_A};
    apply_setting(pat, 6'd3, 1'b1);
    send_file(seq, 1'b0);
  endtask

  // Length zero reads as one
  task automatic test_length_limits();
    logic [PAT_BITS-1:0] pat;
    logic [7:0] seq [$] = '{8'h51, 8'h78};
    pat = random_pattern(1'b0);
    pat[7:0] = 8'h71;
    apply_setting(pat, 6'd0, 1'b0);
    send_file(seq, 1'b1);
  endtask

  // Receiver holds off while a dense stream of matches keeps coming
  task automatic test_result_backlog();
    logic [PAT_BITS-1:0] pat;
    pat = random_pattern(1'b0);
    pat[7:0] = 8'h61;
    apply_setting(pat, 6'd1, 1'b0);
    hold_off_request = HOLD_OFF_LEN;
    for (int i = 0; i < 80; i++)
      send_byte(($urandom_range(0, 9) < 8) ? vary_case(8'h61) : CHAR_NEWLINE, i == 79);
  endtask

  // Sender stops mid-file until every report is out, then finishes the file
  task automatic test_sender_pause();
    for (int i = 0; i < 15; i++) begin
      send_byte(($urandom_range(0, 1)) ? vary_case(8'h61) : CHAR_NEWLINE, 1'b0);
      input_gap(pick_gap());
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
    for (int i = 0; i < 15; i++)
      send_byte(($urandom_range(0, 1)) ? vary_case(8'h61) : 8'($urandom_range(0, 255)), i == 14);
  endtask

  // Random files under a series of settings, including the length extremes
  task automatic test_random_files();
    int          phase_end;
    logic [5:0]  len;
    logic        wide;
    logic        zero_tail;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      zero_tail = 1'b0;
      wide      = 1'b1;
      case (p)
        0: len = 6'($urandom_range(1, 4));
        1: len = 6'd32;
        2: begin len = 6'd63; wide = 1'b0; end
        3: len = 6'd0;
        4: begin len = 6'($urandom_range(1, 3)); zero_tail = 1'b1; end
        default: begin len = 6'($urandom_range(1, 8)); wide = 1'($urandom_range(0, 1)); end
      endcase
      apply_setting(random_pattern(zero_tail), len, wide);
      phase_end = bytes_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (bytes_sent < phase_end) random_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data_byte   = 8'h00;
    in_end_of_file = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_PAT_LOW;
    cfg_data       = '0;
    foreach (pat_word[i]) pat_word[i] = '0;
    pat_len = 6'd1;
    wide_on = 1'b1;
    clear_file();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_case_fold();
    test_length_limits();
    test_result_backlog();
    test_sender_pause();
    test_random_files();

    wait_idle();
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected reports never arrived", $time, pending_reports.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[caseless_substring_line_finder] OK");
    end else begin
      $display("[caseless_substring_line_finder] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/csl_pkg.sv
rtl/csl_matcher.sv
rtl/csl_out_fifo.sv
rtl/caseless_substring_line_finder.sv
tb/caseless_substring_line_finder_tb.sv
